// File: design/cma_pkg.sv
// ----------------------------------------------------------------------------
// cma_pkg: shared types and constants of the circular moving average
// Register codes, widths of the fields, the command word that travels from
// the front end to the back end, and the control group from the top level.
// ----------------------------------------------------------------------------
package cma_pkg;

    // Field and register widths
    localparam int SAMPLE_W   = 16;
    localparam int CFG_WIN_W  = 7;
    localparam int CFG_REC_W  = 15;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Effective window and record values, wide enough for the largest build
    localparam int WIN_EFF_W = 9;
    localparam int REC_EFF_W = 17;

    // Command word field widths, sized for the largest build
    localparam int CMD_ADDR_W = 8;
    localparam int CMD_IDX_W  = 16;

    // Command queue between front and back end
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // Register reset values
    localparam logic [CFG_WIN_W-1:0] WIN_RESET = 7'd40;
    localparam logic [CFG_REC_W-1:0] REC_RESET = 15'd12000;

    // Register indexes (address bit 2)
    localparam logic REG_WINDOW = 1'b0;
    localparam logic REG_RECORD = 1'b1;

    typedef enum logic {
        CMD_SAMPLE,
        CMD_WRAP
    } cmd_kind_t;

    // One unit of work for the back end
    typedef struct packed {
        cmd_kind_t                   kind;
        logic signed [SAMPLE_W-1:0]  x;        // new sample
        logic [CMD_IDX_W-1:0]        idx;      // record position of the result
        logic [CMD_ADDR_W-1:0]       tail_wa;  // delay line write slot
        logic [CMD_ADDR_W-1:0]       tail_ra;  // delay line read slot
        logic [CMD_ADDR_W-1:0]       head_a;   // head store slot
        logic                        sub;      // drop the oldest sample
        logic                        head_we;  // keep sample for the wrap
        logic                        emit;     // produces a result
        logic                        end_rec;  // last sample of the record
        logic                        last;     // last result of the item
    } cmd_t;

    // Control group from the register block
    typedef struct packed {
        logic                  restart;
        logic [WIN_EFF_W-1:0]  win;
        logic [REC_EFF_W-1:0]  rec;
    } ctl_t;

    // Result tag carried alongside the divide pipeline
    typedef struct packed {
        logic [CMD_IDX_W-1:0] idx;
        logic                 last;
    } tag_t;

endpackage

// File: design/cma_if.sv
// ----------------------------------------------------------------------------
// cma_if: stream channels of the circular moving average
// Valid/ready channels for input samples and for averaged results.
// ----------------------------------------------------------------------------
interface cma_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink   (input valid, input sample_value, output ready);
endinterface

interface cma_out_if #(parameter int IDX_W = 14);
    logic               valid;
    logic               ready;
    logic signed [15:0] average_value;
    logic [IDX_W-1:0]   sample_index;
    logic               last_of_run;

    modport source (output valid, output average_value, output sample_index,
                    output last_of_run, input ready);
    modport sink   (input valid, input average_value, input sample_index,
                    input last_of_run, output ready);
endinterface

// File: design/cma_queue.sv
// ----------------------------------------------------------------------------
// cma_queue: command queue between front and back end
// Small register FIFO so that sample intake and result output stall apart.
// ----------------------------------------------------------------------------
module cma_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cma_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output cma_pkg::cmd_t head
);
    import cma_pkg::*;

    cmd_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic                do_push;
    logic                do_pop;

    assign full    = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + (QUEUE_AW+1)'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - (QUEUE_AW+1)'(1);
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// File: design/cma_front.sv
// ----------------------------------------------------------------------------
// cma_front: sample intake and command sequencer
// Tracks the record position, classifies each sample and, after the last
// sample of a record, issues one wrap command per wrapped position.
// ----------------------------------------------------------------------------
module cma_front #(
    parameter int WINDOW_MAX = 64,
    parameter int RECORD_MAX = 16384
) (
    input  logic          clk,
    input  logic          rst_n,
    input  cma_pkg::ctl_t ctl,
    cma_in_if.sink        sample_in,
    input  logic          q_full,
    output logic          q_push,
    output cma_pkg::cmd_t q_cmd
);
    import cma_pkg::*;

    localparam int IDX_W = $clog2(RECORD_MAX);
    localparam int AW    = $clog2(WINDOW_MAX);

    typedef enum logic {
        ST_SAMPLE,
        ST_WRAP
    } state_t;

    state_t           state_reg;
    logic [IDX_W-1:0] count_reg;
    logic [AW-1:0]    k_reg;

    logic [REC_EFF_W-1:0] pos;
    logic [REC_EFF_W-1:0] win;
    logic [REC_EFF_W-1:0] rec;
    logic                 take;
    logic                 is_end;
    logic                 is_emit;
    logic                 wrap_last;

    assign win       = REC_EFF_W'(ctl.win);
    assign rec       = ctl.rec;
    assign pos       = REC_EFF_W'(count_reg);
    assign is_end    = (pos + REC_EFF_W'(1)) >= rec;
    assign is_emit   = (pos + REC_EFF_W'(1)) >= win;
    assign wrap_last = (REC_EFF_W'(k_reg) == (win - REC_EFF_W'(2)));

    assign sample_in.ready = (state_reg == ST_SAMPLE) && !q_full;
    assign take            = (state_reg == ST_SAMPLE) && sample_in.valid && !q_full;
    assign q_push          = take || ((state_reg == ST_WRAP) && !q_full);

    // Command build
    always_comb
    begin
        q_cmd = '0;
        unique case (state_reg)
            ST_SAMPLE:
            begin
                q_cmd.kind    = CMD_SAMPLE;
                q_cmd.x       = sample_in.sample_value;
                q_cmd.idx     = CMD_IDX_W'(count_reg);
                q_cmd.tail_wa = CMD_ADDR_W'(count_reg[AW-1:0]);
                q_cmd.tail_ra = CMD_ADDR_W'(count_reg[AW-1:0] - win[AW-1:0]);
                q_cmd.head_a  = CMD_ADDR_W'(count_reg[AW-1:0]);
                q_cmd.sub     = (pos >= win);
                q_cmd.head_we = !is_emit;
                q_cmd.emit    = is_emit;
                q_cmd.end_rec = is_end;
                q_cmd.last    = is_emit && (!is_end || (win == REC_EFF_W'(1)));
            end
            ST_WRAP:
            begin
                // position k takes back head sample k and drops record
                // position n-w+k
                q_cmd.kind    = CMD_WRAP;
                q_cmd.idx     = CMD_IDX_W'(k_reg);
                q_cmd.tail_ra = CMD_ADDR_W'(rec[AW-1:0] - win[AW-1:0] + k_reg);
                q_cmd.head_a  = CMD_ADDR_W'(k_reg);
                q_cmd.emit    = 1'b1;
                q_cmd.last    = wrap_last;
            end
            default:
            begin
                q_cmd = '0;
            end
        endcase
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SAMPLE;
            count_reg <= '0;
            k_reg     <= '0;
        end
        else if (ctl.restart)
        begin
            state_reg <= ST_SAMPLE;
            count_reg <= '0;
            k_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_SAMPLE:
                begin
                    if (take)
                    begin
                        if (is_end)
                        begin
                            count_reg <= '0;
                            k_reg     <= '0;
                            if (win > REC_EFF_W'(1))
                                state_reg <= ST_WRAP;
                        end
                        else
                        begin
                            count_reg <= count_reg + IDX_W'(1);
                        end
                    end
                end
                ST_WRAP:
                begin
                    if (!q_full)
                    begin
                        if (wrap_last)
                            state_reg <= ST_SAMPLE;
                        else
                            k_reg <= k_reg + AW'(1);
                    end
                end
                default:
                begin
                    state_reg <= ST_SAMPLE;
                end
            endcase
        end
    end

endmodule

// File: design/cma_back.sv
// ----------------------------------------------------------------------------
// cma_back: sample stores, running sum and divide pipeline
// Executes commands: delay line and head store access, running and wrap
// sums, then division by the window through a reciprocal multiply.
// ----------------------------------------------------------------------------
module cma_back #(
    parameter int WINDOW_MAX = 64,
    parameter int RECORD_MAX = 16384
) (
    input  logic          clk,
    input  logic          rst_n,
    input  cma_pkg::ctl_t ctl,
    input  logic          q_valid,
    input  cma_pkg::cmd_t q_cmd,
    output logic          q_pop,
    cma_out_if.source     result_out
);
    import cma_pkg::*;

    localparam int AW     = $clog2(WINDOW_MAX);
    localparam int DEPTH  = 2 ** AW;
    localparam int EW     = $clog2(WINDOW_MAX + 1);
    localparam int IDX_W  = $clog2(RECORD_MAX);
    localparam int SUM_W  = SAMPLE_W + AW;
    // exact for |sum| <= WINDOW_MAX * 2^15 with reciprocal error below w
    localparam int K      = SAMPLE_W + 2 * AW;
    localparam int RCP_W  = K + 1;
    localparam int PROD_W = SUM_W + RCP_W;

    // Reciprocal table: ceil(2^K / w)
    logic [RCP_W-1:0] rcp_tab [WINDOW_MAX+1];
    assign rcp_tab[0] = '0;
    for (genvar g = 1; g <= WINDOW_MAX; g++)
    begin : g_rcp
        localparam logic [63:0] RcpVal = ((64'd1 << K) + 64'(g) - 64'd1) / 64'(g);
        assign rcp_tab[g] = RcpVal[RCP_W-1:0];
    end

    // Sample stores
    logic signed [SAMPLE_W-1:0] tail_mem [DEPTH];
    logic signed [SAMPLE_W-1:0] head_mem [DEPTH];
    logic signed [SAMPLE_W-1:0] tail_rd_reg;
    logic signed [SAMPLE_W-1:0] head_rd_reg;

    // Pipeline registers
    logic                       a_valid_reg;
    cmd_t                       a_cmd_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [SUM_W-1:0]    acc_reg;
    logic                       b_valid_reg;
    logic signed [SUM_W-1:0]    b_sum_reg;
    tag_t                       b_tag_reg;
    logic                       c_valid_reg;
    logic                       c_neg_reg;
    logic [SUM_W-1:0]           c_mag_reg;
    logic [RCP_W-1:0]           c_rcp_reg;
    tag_t                       c_tag_reg;
    logic                       d_valid_reg;
    logic                       d_neg_reg;
    logic [PROD_W-1:0]          d_prod_reg;
    tag_t                       d_tag_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_avg_reg;
    tag_t                       out_tag_reg;

    logic                       adv;
    logic                       pop;
    logic signed [SUM_W-1:0]    tail_sub;
    logic signed [SUM_W-1:0]    win_sum;
    logic signed [SUM_W-1:0]    wrap_sum;
    logic signed [SUM_W-1:0]    emit_val;
    logic [SUM_W-1:0]           mag;
    logic [SAMPLE_W-1:0]        quot;

    // Whole pipeline moves when the output register is free
    assign adv   = !out_valid_reg || result_out.ready;
    assign pop   = adv && q_valid;
    assign q_pop = pop;

    // Store access: one write and one registered read per store
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (q_cmd.kind == CMD_SAMPLE)
                tail_mem[q_cmd.tail_wa[AW-1:0]] <= q_cmd.x;
            if (q_cmd.head_we)
                head_mem[q_cmd.head_a[AW-1:0]] <= q_cmd.x;
            tail_rd_reg <= tail_mem[q_cmd.tail_ra[AW-1:0]];
            head_rd_reg <= head_mem[q_cmd.head_a[AW-1:0]];
        end
    end

    // Window sums
    assign tail_sub = a_cmd_reg.sub ? SUM_W'(tail_rd_reg) : SUM_W'(0);
    assign win_sum  = sum_reg - tail_sub + SUM_W'(a_cmd_reg.x);
    assign wrap_sum = acc_reg + SUM_W'(head_rd_reg) - SUM_W'(tail_rd_reg);
    assign emit_val = (a_cmd_reg.kind == CMD_SAMPLE) ? win_sum : wrap_sum;

    // Sign and magnitude for the divide
    assign mag  = b_sum_reg[SUM_W-1] ? SUM_W'(-b_sum_reg) : SUM_W'(b_sum_reg);
    assign quot = d_prod_reg[K +: SAMPLE_W];

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            sum_reg       <= '0;
        end
        else
        begin
            if (adv)
            begin
                a_valid_reg   <= q_valid;
                b_valid_reg   <= a_valid_reg && a_cmd_reg.emit;
                c_valid_reg   <= b_valid_reg;
                d_valid_reg   <= c_valid_reg;
                out_valid_reg <= d_valid_reg;
            end
            if (ctl.restart)
                sum_reg <= '0;
            else if (adv && a_valid_reg && (a_cmd_reg.kind == CMD_SAMPLE))
                sum_reg <= a_cmd_reg.end_rec ? SUM_W'(0) : win_sum;
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_cmd_reg <= q_cmd;

            if (a_valid_reg)
                acc_reg <= emit_val;
            b_sum_reg     <= emit_val;
            b_tag_reg.idx  <= a_cmd_reg.idx;
            b_tag_reg.last <= a_cmd_reg.last;

            c_neg_reg <= b_sum_reg[SUM_W-1];
            c_mag_reg <= mag;
            c_rcp_reg <= rcp_tab[ctl.win[EW-1:0]];
            c_tag_reg <= b_tag_reg;

            d_neg_reg  <= c_neg_reg;
            d_prod_reg <= PROD_W'(c_mag_reg) * PROD_W'(c_rcp_reg);
            d_tag_reg  <= c_tag_reg;

            out_avg_reg <= d_neg_reg ? SAMPLE_W'(-quot) : SAMPLE_W'(quot);
            out_tag_reg <= d_tag_reg;
        end
    end

    assign result_out.valid         = out_valid_reg;
    assign result_out.average_value = out_avg_reg;
    assign result_out.sample_index  = out_tag_reg.idx[IDX_W-1:0];
    assign result_out.last_of_run   = out_tag_reg.last;

endmodule

// File: design/circular_moving_average_top.sv
// ----------------------------------------------------------------------------
// circular_moving_average_top: circular boxcar moving average
// Register block, front end, command queue and back end.
// ----------------------------------------------------------------------------
// Samples of a record are taken one per clock while the command queue has
// room; each sample from position window-1 on offers its average once it
// has passed the command queue and the back end's a, b, c, d and output
// registers. After the last sample of a record the front end issues the
// wrapped positions 0..window-2 and takes no sample until all are issued.
// The back end runs one command per cycle through one write and one read
// port on each sample store and a reciprocal multiply, and the whole back
// pipeline holds while the output register waits. Writing either register
// restarts the record; write only while no sample or result is in flight.
module circular_moving_average_top #(
    parameter int WINDOW_MAX = 64,
    parameter int RECORD_MAX = 16384
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    cma_in_if.sink      sample_in,
    cma_out_if.source   result_out
);
    import cma_pkg::*;

    logic [CFG_WIN_W-1:0] win_reg;
    logic [CFG_REC_W-1:0] rec_reg;
    logic                 cfg_wr;
    ctl_t                 ctl;
    logic                 q_full;
    logic                 q_push;
    cmd_t                 q_cmd_in;
    logic                 q_valid;
    logic                 q_pop;
    cmd_t                 q_cmd_out;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= WIN_RESET;
            rec_reg <= REC_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_WINDOW: win_reg <= pwdata[CFG_WIN_W-1:0];
                REG_RECORD: rec_reg <= pwdata[CFG_REC_W-1:0];
                default:    win_reg <= win_reg;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (paddr[2])
            REG_WINDOW: prdata = APB_DATA_W'(win_reg);
            REG_RECORD: prdata = APB_DATA_W'(rec_reg);
            default:    prdata = '0;
        endcase
    end

    // Effective window and record length
    always_comb
    begin
        logic [WIN_EFF_W-1:0] win_ext;
        logic [REC_EFF_W-1:0] rec_ext;
        logic [REC_EFF_W-1:0] rec_cl;
        win_ext = WIN_EFF_W'(win_reg);
        rec_ext = REC_EFF_W'(rec_reg);
        if (win_reg == '0)
            ctl.win = WIN_EFF_W'(1);
        else if (win_ext > WIN_EFF_W'(WINDOW_MAX))
            ctl.win = WIN_EFF_W'(WINDOW_MAX);
        else
            ctl.win = win_ext;
        if (rec_ext > REC_EFF_W'(RECORD_MAX))
            rec_cl = REC_EFF_W'(RECORD_MAX);
        else
            rec_cl = rec_ext;
        if (rec_cl < REC_EFF_W'(ctl.win))
            ctl.rec = REC_EFF_W'(ctl.win);
        else
            ctl.rec = rec_cl;
        ctl.restart = cfg_wr;
    end

    cma_front #(
        .WINDOW_MAX (WINDOW_MAX),
        .RECORD_MAX (RECORD_MAX)
    ) u_cma_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .sample_in (sample_in),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_cmd_in)
    );

    cma_queue u_cma_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd_in),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (q_cmd_out)
    );

    cma_back #(
        .WINDOW_MAX (WINDOW_MAX),
        .RECORD_MAX (RECORD_MAX)
    ) u_cma_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .q_valid    (q_valid),
        .q_cmd      (q_cmd_out),
        .q_pop      (q_pop),
        .result_out (result_out)
    );

endmodule

// File: design/cma_checker.sv
// ----------------------------------------------------------------------------
// cma_port_checker: port-level checks of the circular moving average
// Output stall behavior, register read-back and reset state.
// ----------------------------------------------------------------------------
module cma_port_checker #(
    parameter int IDX_W = 14
) (
    input logic               clk,
    input logic               rst_n,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [2:0]         paddr,
    input logic [31:0]        pwdata,
    input logic [31:0]        prdata,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] out_average_value,
    input logic [IDX_W-1:0]   out_sample_index,
    input logic               out_last_of_run
);
    import cma_pkg::*;

    logic [31:0] wr_expect;
    logic        wr_done;

    // Value a register holds after a write to the addressed slot
    assign wr_expect = (paddr[2] == REG_RECORD) ? APB_DATA_W'(pwdata[CFG_REC_W-1:0])
                                                : APB_DATA_W'(pwdata[CFG_WIN_W-1:0]);
    assign wr_done   = psel && penable && pwrite;

    // A stalled result keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_average_value)
            && $stable(out_sample_index) && $stable(out_last_of_run))
        else $error("result changed while stalled");

    // A register read right after a write returns the written field
    a_readback: assert property (@(posedge clk) disable iff (!rst_n)
        wr_done |=> !(psel && !pwrite && (paddr[2] == $past(paddr[2])))
            || (prdata == $past(wr_expect)))
        else $error("register read-back mismatch");

    // Nothing is offered out of reset
    a_reset_idle: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid out of reset");

endmodule

bind circular_moving_average_top cma_port_checker #(
    .IDX_W ($clog2(RECORD_MAX))
) u_cma_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .out_valid         (result_out.valid),
    .out_ready         (result_out.ready),
    .out_average_value (result_out.average_value),
    .out_sample_index  (result_out.sample_index),
    .out_last_of_run   (result_out.last_of_run)
);
